### rtl/plc_pkg.sv
// Shared types and constants for the polyline clipper.
// Used by plc_mul, plc_div, plc_checker, polyline_clip_to_laser_points_unit and its testbench.
package plc_pkg;

    localparam int CW      = 16;   // input coordinate width
    localparam int SW      = 16;   // scale register width
    localparam int PW      = 20;   // scaled coordinate width
    localparam int VW      = 24;   // working value width
    localparam int MW      = 2 * VW;  // product width
    localparam int QW      = 23;   // quotient magnitude bits
    localparam int OW      = 16;   // record position width
    localparam int IN_DW   = 64;   // s_tdata width
    localparam int OUT_DW  = 64;   // m_tdata width
    localparam int SCALE_SHIFT = 12;
    localparam int POS_MAX = 32767;

    localparam logic signed [SW-1:0] SCALE_RESET = 16'sd4096;

    // configuration register indexes
    localparam logic REG_SCALE_X = 1'b0;
    localparam logic REG_SCALE_Y = 1'b1;

    // clip boundaries, in test order
    localparam logic [1:0] EDGE_LEFT   = 2'd0;
    localparam logic [1:0] EDGE_RIGHT  = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_TOP    = 2'd3;

    typedef logic signed [VW-1:0] val_t;
    typedef logic signed [MW-1:0] prod_t;

endpackage

### rtl/plc_mul.sv
// Shared signed multiplier with registered product.
// Depends on plc_pkg.
module plc_mul import plc_pkg::*; (
    input  logic  aclk,
    input  val_t  op_a,
    input  val_t  op_b,
    output prod_t prod
);

    prod_t prod_reg;

    // one product per cycle, result in next cycle
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

### rtl/plc_div.sv
// Iterative restoring divider, one quotient bit per cycle, truncates toward zero.
// Divisor is positive; quotient magnitude fits QW bits. Depends on plc_pkg.
module plc_div import plc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  prod_t num,
    input  val_t  den,
    output logic  done,
    output val_t  quo
);

    localparam int CNTW = $clog2(QW);

    logic [MW-1:0]   rem_reg, rem_next;
    logic [MW-1:0]   den_reg, den_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            neg_reg, neg_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [MW-1:0]   num_abs;
    val_t            q_ext;

    assign num_abs = num[MW-1] ? MW'(-num) : MW'(num);

    // one compare and subtract step per cycle
    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = num_abs;
            den_next = {{(MW-VW){1'b0}}, den} << (QW - 1);
            q_next   = '0;
            cnt_next = CNTW'(QW - 1);
            neg_next = num[MW-1];
            run_next = 1'b1;
        end else if (run_reg) begin
            if (rem_reg >= den_reg) begin
                rem_next = rem_reg - den_reg;
                q_next   = {q_reg[QW-2:0], 1'b1};
            end else begin
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            den_next = den_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign q_ext = val_t'({1'b0, q_reg});
    assign quo   = neg_reg ? -q_ext : q_ext;
    assign done  = done_reg;

endmodule

### rtl/polyline_clip_to_laser_points_unit.sv
// Polyline clipper: scales points, clips each segment to the unit square and
// emits laser records. Depends on plc_pkg, plc_mul and plc_div.
//
// Usage:
//   s_ channel: one point per transfer. s_tdata holds x, y, red, green, blue,
//   blanked, point_last_flag; s_tlast is end_of_frame.
//   m_ channel: zero to three records per point. m_tdata holds pos_x, pos_y,
//   out_red, out_green, out_blue, out_blanked, out_last_point; m_tlast marks
//   the final record caused by a point.
//   cfg_ channel: register writes (index 0 scale_x, index 1 scale_y), always
//   accepted; write only while the block is idle.
// Sequence:
//   A point is handled by a sequencer around one shared 24x24 multiplier and
//   one bit-serial divider. The first point of a polyline is only scaled and
//   stored. A visible segment goes through scaling, a test per clip boundary,
//   four divisions (one quotient bit per cycle) with their position scaling,
//   the issue of the records and the storing of the point.
//   s_tready is high only while the sequencer is idle.
// Reset: clears the previous point, sets both scales to 1.0 and drops m_tvalid.
// Stall: a record waits in the output register; the sequencer holds until the
//   receiver takes it, and the next point may be accepted while the last
//   record of the previous one still waits.
module polyline_clip_to_laser_points_unit import plc_pkg::*; #(
    parameter int COORD_FRAC_BITS = 14,
    parameter int OUTPUT_SCALE    = 32000
) (
    input  logic              aclk,
    input  logic              aresetn,
    // x[15:0], y[31:16], red[39:32], green[47:40], blue[55:48],
    // blanked[56], point_last_flag[57], zero[63:58]
    input  logic [IN_DW-1:0]  s_tdata,
    input  logic              s_tlast,
    input  logic              s_tvalid,
    output logic              s_tready,
    // pos_x[15:0], pos_y[31:16], out_red[39:32], out_green[47:40],
    // out_blue[55:48], out_blanked[56], out_last_point[57], zero[63:58]
    output logic [OUT_DW-1:0] m_tdata,
    output logic              m_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [SW-1:0]     cfg_data
);

    localparam val_t  ONE    = VW'(1) << COORD_FRAC_BITS;
    localparam val_t  OSCALE = VW'(OUTPUT_SCALE);
    localparam prod_t ROUND  = (MW'(1) << COORD_FRAC_BITS) - MW'(1);
    localparam prod_t POS_HI = MW'(POS_MAX);
    localparam prod_t POS_LO = -POS_HI;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MX, ST_MY, ST_NY,
        ST_ESET, ST_MA, ST_MB, ST_CK1, ST_MC, ST_MD, ST_CK2,
        ST_DMUL, ST_DGO, ST_DWAIT, ST_PMUL, ST_PCAP,
        ST_EM0, ST_EM1, ST_EM2, ST_UPD
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [SW-1:0] scale_x_reg, scale_y_reg;

    // current point
    logic signed [CW-1:0] x_reg, y_reg;
    logic [7:0]           red_reg, green_reg, blue_reg;
    logic                 blank_reg, lastf_reg, eof_reg;
    logic signed [PW-1:0] nx_reg, ny_reg;

    // previous point
    logic signed [PW-1:0] prev_x_reg, prev_y_reg;
    logic [7:0]           prev_red_reg, prev_green_reg, prev_blue_reg;
    logic                 prev_blank_reg, prev_lastf_reg, prev_valid_reg;

    // clip state
    logic [1:0] edge_reg;
    logic [1:0] sel_reg;
    logic       neg_reg;
    val_t       rn_reg, rd_reg, en_reg, ed_reg, xn_reg, xd_reg;
    prod_t      a_reg;
    val_t       c_reg;
    logic [OW-1:0] pos_reg [4];

    // output register
    logic [OUT_DW-1:0] m_tdata_reg;
    logic              m_tlast_reg, m_tvalid_reg;

    // shared units
    val_t  op_a, op_b, div_den, div_quo;
    prod_t prod;
    logic  div_start, div_done;

    plc_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    plc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // segment deltas and boundary terms
    val_t dx, dy, p_cur, q_cur, d_sel, tn_sel, base_sel;
    assign dx = VW'(nx_reg) - VW'(prev_x_reg);
    assign dy = VW'(ny_reg) - VW'(prev_y_reg);

    always_comb begin
        case (edge_reg)
            EDGE_LEFT:   begin p_cur = -dx; q_cur = VW'(prev_x_reg) + ONE; end
            EDGE_RIGHT:  begin p_cur = dx;  q_cur = ONE - VW'(prev_x_reg); end
            EDGE_BOTTOM: begin p_cur = -dy; q_cur = VW'(prev_y_reg) + ONE; end
            default:     begin p_cur = dy;  q_cur = ONE - VW'(prev_y_reg); end
        endcase
    end

    // clipped coordinate selection: start x, start y, end x, end y
    always_comb begin
        d_sel    = sel_reg[0] ? dy : dx;
        tn_sel   = sel_reg[1] ? xn_reg : en_reg;
        div_den  = sel_reg[1] ? xd_reg : ed_reg;
        base_sel = sel_reg[0] ? VW'(prev_y_reg) : VW'(prev_x_reg);
    end

    // multiplier operands by step
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_MX:   begin op_a = VW'(x_reg); op_b = VW'(scale_x_reg); end
            ST_MY:   begin op_a = VW'(y_reg); op_b = VW'(scale_y_reg); end
            ST_MA:   begin op_a = rn_reg; op_b = neg_reg ? xd_reg : ed_reg; end
            ST_MB:   begin op_a = neg_reg ? xn_reg : en_reg; op_b = rd_reg; end
            ST_MC:   begin op_a = rn_reg; op_b = neg_reg ? ed_reg : xd_reg; end
            ST_MD:   begin op_a = neg_reg ? en_reg : xn_reg; op_b = rd_reg; end
            ST_DMUL: begin op_a = d_sel; op_b = tn_sel; end
            ST_PMUL: begin op_a = c_reg; op_b = OSCALE; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign div_start = (state_reg == ST_DGO);

    // product views: scaled coordinate, compare, record position
    prod_t nsh, padj, psh;
    logic  cmp_hit;
    logic [OW-1:0] pos_sat;
    assign nsh     = prod >>> SCALE_SHIFT;
    assign cmp_hit = neg_reg ? (a_reg > prod) : (a_reg < prod);
    assign padj    = prod[MW-1] ? prod + ROUND : prod;
    assign psh     = padj >>> COORD_FRAC_BITS;
    always_comb begin
        if (psh > POS_HI)
            pos_sat = OW'(POS_HI);
        else if (psh < POS_LO)
            pos_sat = OW'(POS_LO);
        else
            pos_sat = psh[OW-1:0];
    end

    logic sclip, eclip, has_end, out_free, rec_load;
    assign sclip    = (en_reg != '0);
    assign eclip    = (xn_reg < xd_reg);
    assign has_end  = eclip || eof_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    // a record enters the output register this cycle
    assign rec_load = out_free && (((state_reg == ST_EM0) && sclip) ||
                                   (state_reg == ST_EM1) || (state_reg == ST_EM2));

    // record images
    logic [OUT_DW-1:0] rec_move, rec_start, rec_end;
    assign rec_move  = {6'b0, prev_lastf_reg, 1'b1, 24'b0, pos_reg[1], pos_reg[0]};
    assign rec_start = {6'b0, prev_lastf_reg, (sclip ? 1'b0 : prev_blank_reg),
                        prev_blue_reg, prev_green_reg, prev_red_reg,
                        pos_reg[1], pos_reg[0]};
    assign rec_end   = {6'b0, lastf_reg, 1'b0, blue_reg, green_reg, red_reg,
                        pos_reg[3], pos_reg[2]};

    // sequencer, point state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scale_x_reg    <= SCALE_RESET;
            scale_y_reg    <= SCALE_RESET;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_red_reg   <= '0;
            prev_green_reg <= '0;
            prev_blue_reg  <= '0;
            prev_blank_reg <= 1'b0;
            prev_lastf_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_SCALE_X)
                    scale_x_reg <= cfg_data;
                else
                    scale_y_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready && !rec_load)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        x_reg     <= s_tdata[15:0];
                        y_reg     <= s_tdata[31:16];
                        red_reg   <= s_tdata[39:32];
                        green_reg <= s_tdata[47:40];
                        blue_reg  <= s_tdata[55:48];
                        blank_reg <= s_tdata[56];
                        lastf_reg <= s_tdata[57];
                        eof_reg   <= s_tlast;
                        state_reg <= ST_MX;
                    end
                end
                ST_MX: state_reg <= ST_MY;
                ST_MY: begin
                    nx_reg    <= nsh[PW-1:0];
                    state_reg <= ST_NY;
                end
                ST_NY: begin
                    ny_reg   <= nsh[PW-1:0];
                    en_reg   <= '0;
                    ed_reg   <= VW'(1);
                    xn_reg   <= VW'(1);
                    xd_reg   <= VW'(1);
                    edge_reg <= EDGE_LEFT;
                    state_reg <= prev_valid_reg ? ST_ESET : ST_UPD;
                end
                ST_ESET: begin
                    if (p_cur == '0) begin
                        if (q_cur[VW-1])
                            state_reg <= ST_UPD;
                        else if (edge_reg == EDGE_TOP) begin
                            sel_reg   <= '0;
                            state_reg <= ST_DMUL;
                        end else
                            edge_reg <= edge_reg + 1'b1;
                    end else begin
                        neg_reg   <= p_cur[VW-1];
                        rn_reg    <= p_cur[VW-1] ? -q_cur : q_cur;
                        rd_reg    <= p_cur[VW-1] ? -p_cur : p_cur;
                        state_reg <= ST_MA;
                    end
                end
                ST_MA: state_reg <= ST_MB;
                ST_MB: begin
                    a_reg     <= prod;
                    state_reg <= ST_CK1;
                end
                ST_CK1: state_reg <= cmp_hit ? ST_UPD : ST_MC;
                ST_MC: state_reg <= ST_MD;
                ST_MD: begin
                    a_reg     <= prod;
                    state_reg <= ST_CK2;
                end
                ST_CK2: begin
                    // tighten entry or exit fraction
                    if (cmp_hit) begin
                        if (neg_reg) begin
                            en_reg <= rn_reg;
                            ed_reg <= rd_reg;
                        end else begin
                            xn_reg <= rn_reg;
                            xd_reg <= rd_reg;
                        end
                    end
                    if (edge_reg == EDGE_TOP) begin
                        sel_reg   <= '0;
                        state_reg <= ST_DMUL;
                    end else begin
                        edge_reg  <= edge_reg + 1'b1;
                        state_reg <= ST_ESET;
                    end
                end
                ST_DMUL: state_reg <= ST_DGO;
                ST_DGO:  state_reg <= ST_DWAIT;
                ST_DWAIT: begin
                    if (div_done) begin
                        c_reg     <= base_sel + div_quo;
                        state_reg <= ST_PMUL;
                    end
                end
                ST_PMUL: state_reg <= ST_PCAP;
                ST_PCAP: begin
                    pos_reg[sel_reg] <= pos_sat;
                    if (sel_reg == 2'd3)
                        state_reg <= ST_EM0;
                    else begin
                        sel_reg   <= sel_reg + 1'b1;
                        state_reg <= ST_DMUL;
                    end
                end
                ST_EM0: begin
                    if (!sclip)
                        state_reg <= ST_EM1;
                    else if (out_free) begin
                        m_tdata_reg  <= rec_move;
                        m_tlast_reg  <= 1'b0;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_EM1;
                    end
                end
                ST_EM1: begin
                    if (out_free) begin
                        m_tdata_reg  <= rec_start;
                        m_tlast_reg  <= !has_end;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= has_end ? ST_EM2 : ST_UPD;
                    end
                end
                ST_EM2: begin
                    if (out_free) begin
                        m_tdata_reg  <= rec_end;
                        m_tlast_reg  <= 1'b1;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    prev_x_reg     <= nx_reg;
                    prev_y_reg     <= ny_reg;
                    prev_red_reg   <= red_reg;
                    prev_green_reg <= green_reg;
                    prev_blue_reg  <= blue_reg;
                    prev_blank_reg <= blank_reg;
                    prev_lastf_reg <= lastf_reg;
                    prev_valid_reg <= !eof_reg;
                    state_reg      <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tvalid  = m_tvalid_reg;

endmodule

### rtl/plc_checker.sv
// Port-level checks for the polyline clipper, bound to the top level.
// Depends on plc_pkg.
module plc_checker import plc_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [OUT_DW-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tvalid,
    input logic              m_tready
);

    // reset leaves no record pending and the input open
    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("state after reset not clean");

    // one point at a time: busy right after an input transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a point is in work");

    // stalled record stays
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("record dropped under stall");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("record changed under stall");

endmodule

bind polyline_clip_to_laser_points_unit plc_checker u_plc_checker (.*);

### tb/tb_polyline_clip_to_laser_points_unit.sv
// Testbench for polyline_clip_to_laser_points_unit: directed and random point streams,
// checked against an in-bench clipper model. Depends on plc_pkg and the unit RTL only.
module tb_polyline_clip_to_laser_points_unit import plc_pkg::*;;

    localparam int  FRAC      = 14;
    localparam int  OUT_SCALE = 32000;
    localparam int  STALL_LIMIT = 4000;
    localparam int  SETTLE    = 250;   // longer than one visible segment
    localparam int  HOLD_OFF  = 400;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       blanked;
        logic       lastf;
        logic       eof;
    } point_t;

    typedef struct {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        blanked;
        logic        lastp;
        logic        run_end;
    } record_t;

    logic              aclk;
    logic              aresetn;
    logic [IN_DW-1:0]  s_tdata;
    logic              s_tlast;
    logic              s_tvalid;
    logic              s_tready;
    logic [OUT_DW-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [SW-1:0]     cfg_data;

    // shadow state of the clipper
    longint   scl_x, scl_y;
    longint   held_x, held_y;
    logic [7:0] held_r, held_g, held_b;
    logic     held_blank, held_last, held_valid;

    record_t  pending_records[$];
    int       errors;
    int       points_sent;
    int       records_seen;
    int       quiet_cycles;
    bit       calm;        // no idling on either side
    bit       hold_req;    // ask the receiver for a long hold-off

    polyline_clip_to_laser_points_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // one boundary test; entry en/ed, exit xn/xd
    function automatic bit clip_boundary(input longint p, input longint q,
                                         inout longint en, inout longint ed,
                                         inout longint xn, inout longint xd);
        longint rn, rd;
        if (p == 0) return q >= 0;
        if (p < 0) begin
            rn = -q;
            rd = -p;
            if (rn * xd > xn * rd) return 0;
            if (rn * ed > en * rd) begin
                en = rn;
                ed = rd;
            end
        end else begin
            rn = q;
            rd = p;
            if (rn * ed < en * rd) return 0;
            if (rn * xd < xn * rd) begin
                xn = rn;
                xd = rd;
            end
        end
        return 1;
    endfunction

    function automatic logic [15:0] laser_pos(input longint c);
        longint v;
        v = (c * OUT_SCALE) / (longint'(1) << FRAC);
        if (v > POS_MAX) v = POS_MAX;
        if (v < -POS_MAX) v = -POS_MAX;
        return v[15:0];
    endfunction

    function automatic record_t make_record(input longint cx, input longint cy,
                                            input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic blank,
                                            input logic lastp);
        record_t rec;
        rec.pos_x = laser_pos(cx);
        rec.pos_y = laser_pos(cy);
        rec.red = r;
        rec.green = g;
        rec.blue = b;
        rec.blanked = blank;
        rec.lastp = lastp;
        rec.run_end = 1'b0;
        return rec;
    endfunction

    // clip the segment ending at this point and queue the records it yields
    task automatic predict_records(input point_t pt);
        longint one, nx, ny, dx, dy, en, ed, xn, xd;
        record_t recs[$];
        bit visible, sclip, eclip;
        one = longint'(1) << FRAC;
        nx = (longint'(pt.x) * scl_x) >>> SCALE_SHIFT;
        ny = (longint'(pt.y) * scl_y) >>> SCALE_SHIFT;
        if (held_valid) begin
            dx = nx - held_x;
            dy = ny - held_y;
            en = 0; ed = 1; xn = 1; xd = 1;
            visible = clip_boundary(-dx, held_x + one, en, ed, xn, xd) &&
                      clip_boundary(dx, one - held_x, en, ed, xn, xd) &&
                      clip_boundary(-dy, held_y + one, en, ed, xn, xd) &&
                      clip_boundary(dy, one - held_y, en, ed, xn, xd);
            if (visible) begin
                sclip = en > 0;
                eclip = xn < xd;
                if (sclip)
                    recs = {recs, make_record(held_x + (dx * en) / ed,
                        held_y + (dy * en) / ed, 8'd0, 8'd0, 8'd0, 1'b1, held_last)};
                recs = {recs, make_record(held_x + (dx * en) / ed,
                    held_y + (dy * en) / ed, held_r, held_g, held_b,
                    sclip ? 1'b0 : held_blank, held_last)};
                if (eclip || pt.eof)
                    recs = {recs, make_record(held_x + (dx * xn) / xd,
                        held_y + (dy * xn) / xd, pt.red, pt.green, pt.blue, 1'b0,
                        pt.lastf)};
                recs[recs.size() - 1].run_end = 1'b1;
                pending_records = {pending_records, recs};
            end
        end
        held_x = nx;
        held_y = ny;
        held_r = pt.red;
        held_g = pt.green;
        held_b = pt.blue;
        held_blank = pt.blanked;
        held_last = pt.lastf;
        held_valid = !pt.eof;
    endtask

    // offer one point, predict on transfer, then maybe idle
    task automatic send_point(input point_t pt);
        s_tdata  <= {6'd0, pt.lastf, pt.blanked, pt.blue, pt.green, pt.red, pt.y, pt.x};
        s_tlast  <= pt.eof;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_records(pt);
        points_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic send_xy(input int x, input int y, input bit eof);
        point_t pt;
        pt.x = x[15:0];
        pt.y = y[15:0];
        pt.red = 8'($urandom);
        pt.green = 8'($urandom);
        pt.blue = 8'($urandom);
        pt.blanked = 1'($urandom);
        pt.lastf = 1'($urandom);
        pt.eof = eof;
        send_point(pt);
    endtask

    // wait until the unit is idle, then write one scale register
    task automatic write_scale(input logic idx, input int value);
        s_tvalid <= 1'b0;
        wait (pending_records.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SCALE_X) scl_x = longint'($signed(value[15:0]));
        else scl_y = longint'($signed(value[15:0]));
    endtask

    task automatic test_first_points;
        send_xy(0, 0, 1);                   // one-point polyline
        send_xy(100, 200, 0);               // first point, stored only
        send_xy(-300, 4000, 0);             // inside, not final
        send_xy(-300, 4000, 0);             // zero length inside
        send_xy(2000, -1000, 1);            // frame end emits end point
    endtask

    task automatic test_clip_cases;
        send_xy(-32768, 0, 0);              // start outside left
        send_xy(32767, 0, 0);               // crosses both sides
        send_xy(32767, 32767, 0);           // fully outside
        send_xy(-32768, -32768, 0);         // diagonal through the square
        send_xy(-32768, -32768, 0);         // zero length outside
        send_xy(0, 16384, 0);               // on the top boundary
        send_xy(0, -30000, 1);              // end clipped and frame end
        send_xy(16384, 16384, 0);
        send_xy(-16384, -16384, 1);         // corner to corner
    endtask

    task automatic test_scales;
        write_scale(REG_SCALE_X, -32768);
        write_scale(REG_SCALE_Y, 32767);
        send_xy(1000, 500, 0);
        send_xy(-1000, -500, 0);
        send_xy(32767, -32768, 1);
        write_scale(REG_SCALE_X, 0);
        write_scale(REG_SCALE_Y, -32768);
        send_xy(5000, 200, 0);
        send_xy(-5000, -200, 1);
        write_scale(REG_SCALE_X, 32767);
        write_scale(REG_SCALE_Y, 0);
        send_xy(-2000, 7000, 0);
        send_xy(2500, -7000, 1);
        write_scale(REG_SCALE_X, 4096);
        write_scale(REG_SCALE_Y, 4096);
    endtask

    // random polylines, mostly near the square, some at full range
    task automatic run_polylines(input int n_points);
        int left, len;
        point_t pt;
        left = n_points;
        while (left > 0) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len && left > 0; k++) begin
                pt.red = 8'($urandom);
                pt.green = 8'($urandom);
                pt.blue = 8'($urandom);
                pt.blanked = 1'($urandom);
                pt.lastf = 1'($urandom);
                pt.eof = (k == len - 1) || ($urandom_range(0, 19) == 0);
                if ($urandom_range(0, 3) == 0) begin
                    pt.x = 16'($urandom);
                    pt.y = 16'($urandom);
                end else begin
                    pt.x = 16'($urandom_range(0, 49152) - 24576);
                    pt.y = 16'($urandom_range(0, 49152) - 24576);
                end
                send_point(pt);
                left--;
            end
        end
    endtask

    task automatic test_random;
        run_polylines(80);
        write_scale(REG_SCALE_X, 2048);
        write_scale(REG_SCALE_Y, -6144);
        run_polylines(50);
        write_scale(REG_SCALE_X, 4096);
        write_scale(REG_SCALE_Y, 4096);
    endtask

    task automatic test_backpressure;
        hold_req = 1'b1;
        run_polylines(20);
    endtask

    task automatic test_no_idle;
        calm = 1'b1;
        run_polylines(60);
    endtask

    // stimulus sequence
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SCALE_X;
        cfg_data = '0;
        errors = 0;
        points_sent = 0;
        records_seen = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        scl_x = 4096;
        scl_y = 4096;
        held_x = 0;
        held_y = 0;
        {held_r, held_g, held_b} = '0;
        held_blank = 1'b0;
        held_last = 1'b0;
        held_valid = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_points;
        test_clip_cases;
        test_scales;
        test_random;
        test_backpressure;
        test_no_idle;

        s_tvalid <= 1'b0;
        wait (pending_records.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        $display("Covered %0d points and %0d laser records, six scale settings,",
                 points_sent, records_seen);
        $display("clipped and invisible segments, frame ends and a long output stall.");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // record checker
    always @(posedge aclk) begin
        record_t want;
        if (aresetn && m_tvalid && m_tready) begin
            records_seen++;
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected record %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = pending_records.pop_front();
                if (m_tdata[15:0] !== want.pos_x || m_tdata[31:16] !== want.pos_y ||
                    m_tdata[39:32] !== want.red || m_tdata[47:40] !== want.green ||
                    m_tdata[55:48] !== want.blue || m_tdata[56] !== want.blanked ||
                    m_tdata[57] !== want.lastp || m_tdata[63:58] !== 6'd0 ||
                    m_tlast !== want.run_end) begin
                    $display("%0t: mismatch exp x=%h y=%h rgb=%h%h%h bl=%b lp=%b tl=%b",
                             $time, want.pos_x, want.pos_y, want.red, want.green,
                             want.blue, want.blanked, want.lastp, want.run_end);
                    $display("%0t:          act x=%h y=%h rgb=%h bl=%b lp=%b tl=%b pad=%h",
                             $time, m_tdata[15:0], m_tdata[31:16], m_tdata[55:32],
                             m_tdata[56], m_tdata[57], m_tlast, m_tdata[63:58]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
